FILE: hdl/sitoa_pkg.sv
// shared types and constants for the signed integer to decimal ascii block
// no dependencies
package sitoa_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int unsigned STEP_W     = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // control shared by every digit cell
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: hdl/sitoa_digit_cell.sv
// one bcd digit cell of the shift-and-add-3 chain
// depends on sitoa_pkg
module sitoa_digit_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sitoa_pkg::cell_ctrl_t ctrl_i,
  input  logic                  bit_i,
  output logic                  bit_o,
  output logic [3:0]            digit_o
);

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  // add 3 when the digit would overflow past 9 after doubling
  assign adj   = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign bit_o = adj[3];

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.shift) begin
      digit_d = {adj[2:0], bit_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

FILE: hdl/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii text stream
// depends on sitoa_pkg and sitoa_digit_cell
//
// usage
//   input stream: one beat per number, tdata holds the 32-bit two's complement
//   value. output stream: one beat per character, most significant first,
//   an optional '-' then 1 to 10 digits with no leading zeros; tlast marks
//   the final character of each number.
// timing
//   after a beat is taken the magnitude is shifted msb first through a row of
//   ten bcd cells, one bit per cycle, in 32 steps; a further state then finds
//   the leading digit, then one character leaves per cycle while the receiver
//   keeps tready high. no new number is taken until the last character of the
//   current one is in the output register.
// reset
//   rst_ni clears the state machine, the cells and the output valid; the
//   block is ready for a number right after reset.
// stalls
//   characters wait in the output register while tready is low; the last
//   character may wait there while the next number is already taken in.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [5:0] ascii_char, [7:6] zero
  output logic        m_axis_tlast_o    // last_char
);

  localparam int unsigned ND  = sitoa_pkg::NUM_DIGITS;
  localparam int unsigned IW  = sitoa_pkg::DIGIT_IDX_W;
  localparam int unsigned SW  = sitoa_pkg::STEP_W;
  localparam int unsigned VW  = sitoa_pkg::VALUE_W;
  localparam int unsigned CW  = sitoa_pkg::CHAR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  state_e              state_q;
  logic [VW-1:0]       mag_q;
  logic [SW-1:0]       step_q;
  logic                neg_q;
  logic [IW-1:0]       ptr_q;
  logic                out_valid_q;
  logic [CW-1:0]       out_char_q;
  logic                out_last_q;

  logic                in_beat;
  logic                out_free;
  logic [VW-1:0]       mag_in;
  logic [IW-1:0]       lead_idx;
  logic [3:0]          cur_digit;
  sitoa_pkg::cell_ctrl_t ctrl;

  logic [ND:0]         chain;
  logic [3:0]          digits [ND];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // magnitude as unsigned; the most negative value maps to 2^31
  assign mag_in = s_axis_tdata_i[VW-1] ? (VW'(0) - s_axis_tdata_i) : s_axis_tdata_i;

  assign ctrl.clr   = in_beat;
  assign ctrl.shift = (state_q == ST_CONV);

  // chain of bcd cells, cell 0 is the ones digit and takes the magnitude msb
  assign chain[0] = mag_q[VW-1];

  for (genvar g = 0; g < ND; g++) begin : g_cell
    sitoa_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (chain[g]),
      .bit_o   (chain[g+1]),
      .digit_o (digits[g])
    );
  end

  // highest nonzero digit, or the ones digit when the value is zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < ND; i++) begin
      if (digits[i] != 4'd0) begin
        lead_idx = IW'(i);
      end
    end
  end

  assign cur_digit = digits[ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      step_q      <= '0;
      neg_q       <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            mag_q   <= mag_in;
            neg_q   <= s_axis_tdata_i[VW-1];
            step_q  <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q  <= {mag_q[VW-2:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (step_q == SW'(VW - 1)) begin
            state_q <= ST_FIND;
          end
        end
        ST_FIND: begin
          ptr_q   <= lead_idx;
          state_q <= neg_q ? ST_SIGN : ST_DIGIT;
        end
        ST_SIGN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= sitoa_pkg::CHAR_MINUS;
            out_last_q  <= 1'b0;
            state_q     <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_char_q  <= sitoa_pkg::CHAR_ZERO + {2'b00, cur_digit};
            out_last_q  <= (ptr_q == '0);
            if (ptr_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              ptr_q <= ptr_q - 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_char_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
